// ===== src/general_graph_blossom_matching_top_assert.svh =====
// assertion helpers shared by the matching block
`ifndef GENERAL_GRAPH_BLOSSOM_MATCHING_TOP_ASSERT_SVH
`define GENERAL_GRAPH_BLOSSOM_MATCHING_TOP_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define GGBM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggbm assertion failed");

// consequent holds in the cycle after the antecedent
`define GGBM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggbm assertion failed");

`endif

// ===== src/ggbm_pkg.sv =====
package ggbm_pkg;

   localparam int DEF_MAX_VERTICES = 64;
   localparam int DEF_MAX_EDGES    = 256;
   localparam int DEF_STAMP_WIDTH  = 16;

   localparam int ACTION_WIDTH = 2;
   localparam int PORT_VW      = 7;

   localparam logic [ACTION_WIDTH-1:0] ACT_ADD_EDGE  = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_AUGMENT   = 2'd1;
   localparam logic [ACTION_WIDTH-1:0] ACT_READ_MATE = 2'd2;

   localparam logic [1:0] LBL_NONE  = 2'd0;
   localparam logic [1:0] LBL_OUTER = 2'd1;
   localparam logic [1:0] LBL_INNER = 2'd2;

   typedef struct packed {
      logic [ACTION_WIDTH-1:0] action;
      logic [PORT_VW-1:0]      first_vertex;
      logic [PORT_VW-1:0]      second_vertex;
   } cmd_type;

   typedef struct packed {
      logic               found;
      logic [PORT_VW-1:0] mate;
      logic               status;
   } rsp_type;

endpackage

// ===== src/general_graph_blossom_matching_top.sv =====
// an augment from an unmatched start first resets every vertex entry, then runs a
//   data dependent search (work per edge scanned and per base hop); read mate, add
//   edge, a bad vertex or spare action and an augment from a matched start run no search
// flow: one item at a time; the next request is taken the cycle after the
//   result is loaded, and the result waits while the result register is full
// reset: synchronous; all MAX_VERTICES + 1 vertex entries are swept after reset
//   with no request taken; a stamp wrap costs another sweep of the same entries
module general_graph_blossom_matching_top import ggbm_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [PORT_VW-1:0]      req_first_vertex,
   input  logic [PORT_VW-1:0]      req_second_vertex,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_found,
   output logic [PORT_VW-1:0]      rsp_mate,
   output logic                    rsp_status
);

   cmd_type cmd;
   rsp_type core_rsp;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    core_ready;
   logic    core_done;
   logic    start;
   logic    slot_free;

   assign cmd.action        = req_action;
   assign cmd.first_vertex  = req_first_vertex;
   assign cmd.second_vertex = req_second_vertex;

   assign req_ready = core_ready;
   assign start     = req_valid && core_ready;
   // result register frees up in the same cycle its beat is taken
   assign slot_free = !rsp_valid_ff || rsp_ready;

   ggbm_core #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES),
      .STAMP_WIDTH  (STAMP_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .cmd       (cmd),
      .slot_free (slot_free),
      .ready     (core_ready),
      .done      (core_done),
      .rsp       (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_done) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_found  = rsp_ff.found;
   assign rsp_mate   = rsp_ff.mate;
   assign rsp_status = rsp_ff.status;

endmodule

// ===== src/ggbm_core.sv =====
`include "general_graph_blossom_matching_top_assert.svh"

module ggbm_core import ggbm_pkg::*; #(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES,
   parameter int MAX_EDGES    = DEF_MAX_EDGES,
   parameter int STAMP_WIDTH  = DEF_STAMP_WIDTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  cmd_type cmd,
   input  logic    slot_free,
   output logic    ready,
   output logic    done,
   output rsp_type rsp
);

   localparam int NV     = MAX_VERTICES + 1;
   localparam int VW     = $clog2(NV);
   localparam int ECAP   = 2 * MAX_EDGES;
   localparam int LW     = $clog2(ECAP + 1);
   localparam int EDEPTH = ECAP + MAX_VERTICES;
   localparam int EAW    = $clog2(EDEPTH);
   localparam int QW     = $clog2(MAX_VERTICES + 1);
   localparam int SW     = STAMP_WIDTH;

   typedef struct packed {
      logic [LW-1:0] head;
      logic [SW-1:0] stamp;
      logic [VW-1:0] base;
      logic [VW-1:0] parent;
      logic [1:0]    label;
      logic [VW-1:0] mate;
   } vrec_type;

   typedef struct packed {
      logic [VW-1:0] target;
      logic [LW-1:0] link;
   } erec_type;

   typedef enum logic [34:0] {
      ST_IDLE      = 35'b1 << 0,
      ST_BOOT      = 35'b1 << 1,
      ST_FINISH    = 35'b1 << 2,
      ST_ADD_U     = 35'b1 << 3,
      ST_ADD_RDV   = 35'b1 << 4,
      ST_ADD_V     = 35'b1 << 5,
      ST_READ      = 35'b1 << 6,
      ST_AUG_CHK   = 35'b1 << 7,
      ST_INIT_WR   = 35'b1 << 8,
      ST_SEED      = 35'b1 << 9,
      ST_Q_CHK     = 35'b1 << 10,
      ST_Q_GET     = 35'b1 << 11,
      ST_U_HEAD    = 35'b1 << 12,
      ST_E_CHK     = 35'b1 << 13,
      ST_E_GET     = 35'b1 << 14,
      ST_ROOT      = 35'b1 << 15,
      ST_GOT_RU    = 35'b1 << 16,
      ST_GOT_RV    = 35'b1 << 17,
      ST_V_LAB     = 35'b1 << 18,
      ST_M_WR      = 35'b1 << 19,
      ST_FLIP_W    = 35'b1 << 20,
      ST_FLIP_PW   = 35'b1 << 21,
      ST_FLIP_DONE = 35'b1 << 22,
      ST_CB_START  = 35'b1 << 23,
      ST_STAMP_WR  = 35'b1 << 24,
      ST_CB_RB     = 35'b1 << 25,
      ST_CB_LOOP   = 35'b1 << 26,
      ST_CB_CHK    = 35'b1 << 27,
      ST_CB_M      = 35'b1 << 28,
      ST_CB_NEXT   = 35'b1 << 29,
      ST_CT_BEGIN  = 35'b1 << 30,
      ST_CT_R      = 35'b1 << 31,
      ST_CT_A      = 35'b1 << 32,
      ST_CT_B      = 35'b1 << 33,
      ST_CT_RB     = 35'b1 << 34
   } state_type;

   // memories
   vrec_type vmem [NV];
   erec_type emem [EDEPTH];
   vrec_type v_rd_ff;
   erec_type e_rd_ff;

   logic            v_we;
   logic [VW-1:0]   v_waddr;
   logic [VW-1:0]   v_raddr;
   vrec_type        v_wrec;
   logic            e_we;
   logic [EAW-1:0]  e_waddr;
   logic [EAW-1:0]  e_raddr;
   erec_type        e_wdata;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;
   logic [VW-1:0] s_ff, s_in;
   logic [VW-1:0] u_ff, u_in;
   logic [VW-1:0] v_ff, v_in;
   logic [VW-1:0] w_ff, w_in;
   logic [VW-1:0] rx_ff, rx_in;
   logic [VW-1:0] ru_ff, ru_in;
   logic [VW-1:0] a_ff, a_in;
   logic [VW-1:0] b_ff, b_in;
   logic [VW-1:0] base_ff, base_in;
   logic [VW-1:0] ca_ff, ca_in;
   logic [VW-1:0] cb_ff, cb_in;
   logic [VW-1:0] pb_ff, pb_in;
   logic [VW-1:0] ix_ff, ix_in;
   logic [VW-1:0] pw_hold_ff;
   logic [LW-1:0] e_ff, e_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [SW-1:0] st_ff, st_in;
   logic [QW-1:0] qrd_ff, qrd_in;
   logic [QW-1:0] qwr_ff, qwr_in;
   logic          ct2_ff, ct2_in;
   logic          self_ff, self_in;
   logic          found_ff, found_in;
   logic [VW-1:0] mate_ff, mate_in;
   logic          status_ff, status_in;

   logic          push_req;
   logic [VW-1:0] push_vtx;
   logic          call_req;
   logic [VW-1:0] call_x;
   state_type     call_ret;

   logic          a_ok, b_ok;
   logic [VW-1:0] x_cmd, y_cmd;
   logic [SW-1:0] st_next;

   assign a_ok  = (cmd.first_vertex != '0) &&
                  (32'(cmd.first_vertex) <= 32'(MAX_VERTICES));
   assign b_ok  = (cmd.second_vertex != '0) &&
                  (32'(cmd.second_vertex) <= 32'(MAX_VERTICES));
   assign x_cmd = VW'(cmd.first_vertex);
   assign y_cmd = VW'(cmd.second_vertex);
   assign st_next = st_ff + SW'(1);

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      s_in      = s_ff;
      u_in      = u_ff;
      v_in      = v_ff;
      w_in      = w_ff;
      rx_in     = rx_ff;
      ru_in     = ru_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      base_in   = base_ff;
      ca_in     = ca_ff;
      cb_in     = cb_ff;
      pb_in     = pb_ff;
      ix_in     = ix_ff;
      e_in      = e_ff;
      fill_in   = fill_ff;
      st_in     = st_ff;
      qrd_in    = qrd_ff;
      qwr_in    = qwr_ff;
      ct2_in    = ct2_ff;
      self_in   = self_ff;
      found_in  = found_ff;
      mate_in   = mate_ff;
      status_in = status_ff;
      v_we      = 1'b0;
      v_waddr   = '0;
      v_raddr   = '0;
      v_wrec    = v_rd_ff;
      e_we      = 1'b0;
      e_waddr   = '0;
      e_raddr   = '0;
      e_wdata   = '0;
      push_req  = 1'b0;
      push_vtx  = '0;
      call_req  = 1'b0;
      call_x    = '0;
      call_ret  = ST_IDLE;
      done      = 1'b0;

      case (state_ff)
         ST_BOOT: begin
            v_we        = 1'b1;
            v_waddr     = ix_ff;
            v_wrec      = '0;
            v_wrec.base = ix_ff;
            ix_in       = ix_ff + VW'(1);
            if (ix_ff == VW'(NV - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               found_in  = 1'b0;
               mate_in   = '0;
               status_in = 1'b0;
               state_in  = ST_FINISH;
               case (cmd.action)
                  ACT_ADD_EDGE: begin
                     if (a_ok && b_ok) begin
                        if (({1'b0, fill_ff} + (LW + 1)'(2)) > (LW + 1)'(ECAP)) begin
                           status_in = 1'b1;
                        end else begin
                           u_in     = x_cmd;
                           v_in     = y_cmd;
                           v_raddr  = x_cmd;
                           state_in = ST_ADD_U;
                        end
                     end
                  end
                  ACT_AUGMENT: begin
                     if (a_ok) begin
                        s_in     = x_cmd;
                        v_raddr  = x_cmd;
                        state_in = ST_AUG_CHK;
                     end
                  end
                  ACT_READ_MATE: begin
                     if (a_ok) begin
                        v_raddr  = x_cmd;
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_ADD_U: begin
            e_we           = 1'b1;
            e_waddr        = EAW'(fill_ff);
            e_wdata.target = v_ff;
            e_wdata.link   = v_rd_ff.head;
            v_we           = 1'b1;
            v_waddr        = u_ff;
            v_wrec.head    = fill_ff + LW'(1);
            fill_in        = fill_ff + LW'(1);
            state_in       = ST_ADD_RDV;
         end
         ST_ADD_RDV: begin
            v_raddr  = v_ff;
            state_in = ST_ADD_V;
         end
         ST_ADD_V: begin
            e_we           = 1'b1;
            e_waddr        = EAW'(fill_ff);
            e_wdata.target = u_ff;
            e_wdata.link   = v_rd_ff.head;
            v_we           = 1'b1;
            v_waddr        = v_ff;
            v_wrec.head    = fill_ff + LW'(1);
            fill_in        = fill_ff + LW'(1);
            state_in       = ST_FINISH;
         end
         ST_READ: begin
            mate_in  = v_rd_ff.mate;
            state_in = ST_FINISH;
         end
         ST_AUG_CHK: begin
            if (v_rd_ff.mate != '0) begin
               mate_in  = v_rd_ff.mate;
               state_in = ST_FINISH;
            end else begin
               ix_in    = '0;
               v_raddr  = '0;
               state_in = ST_INIT_WR;
            end
         end
         // one entry per cycle: write back entry ix while reading ix + 1
         ST_INIT_WR: begin
            v_we          = 1'b1;
            v_waddr       = ix_ff;
            v_wrec.label  = LBL_NONE;
            v_wrec.parent = '0;
            v_wrec.base   = ix_ff;
            if (ix_ff == VW'(NV - 1)) begin
               v_raddr  = s_ff;
               state_in = ST_SEED;
            end else begin
               ix_in   = ix_ff + VW'(1);
               v_raddr = ix_ff + VW'(1);
            end
         end
         ST_SEED: begin
            v_we         = 1'b1;
            v_waddr      = s_ff;
            v_wrec.label = LBL_OUTER;
            qrd_in       = '0;
            qwr_in       = '0;
            e_we           = 1'b1;
            e_waddr        = EAW'(ECAP);
            e_wdata.target = s_ff;
            qwr_in         = QW'(1);
            state_in     = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            if (qrd_ff < qwr_ff) begin
               e_raddr  = EAW'(ECAP) + EAW'(qrd_ff);
               qrd_in   = qrd_ff + QW'(1);
               state_in = ST_Q_GET;
            end else begin
               found_in = 1'b0;
               mate_in  = '0;
               state_in = ST_FINISH;
            end
         end
         ST_Q_GET: begin
            u_in     = e_rd_ff.target;
            v_raddr  = e_rd_ff.target;
            state_in = ST_U_HEAD;
         end
         ST_U_HEAD: begin
            e_in     = v_rd_ff.head;
            state_in = ST_E_CHK;
         end
         ST_E_CHK: begin
            if (e_ff == '0) begin
               state_in = ST_Q_CHK;
            end else begin
               e_raddr  = EAW'(e_ff - LW'(1));
               state_in = ST_E_GET;
            end
         end
         ST_E_GET: begin
            v_in     = e_rd_ff.target;
            e_in     = e_rd_ff.link;
            call_req = 1'b1;
            call_x   = u_ff;
            call_ret = ST_GOT_RU;
         end
         // walk the base chain to the blossom root
         ST_ROOT: begin
            if (v_rd_ff.base == rx_ff) begin
               v_raddr  = rx_ff;
               state_in = ret_ff;
            end else begin
               rx_in   = v_rd_ff.base;
               v_raddr = v_rd_ff.base;
            end
         end
         ST_GOT_RU: begin
            ru_in    = rx_ff;
            call_req = 1'b1;
            call_x   = v_ff;
            call_ret = ST_GOT_RV;
         end
         ST_GOT_RV: begin
            if (ru_ff == rx_ff) begin
               state_in = ST_E_CHK;
            end else begin
               v_raddr  = v_ff;
               state_in = ST_V_LAB;
            end
         end
         ST_V_LAB: begin
            case (v_rd_ff.label)
               LBL_INNER: begin
                  state_in = ST_E_CHK;
               end
               LBL_NONE: begin
                  v_we          = 1'b1;
                  v_waddr       = v_ff;
                  v_wrec.label  = LBL_INNER;
                  v_wrec.parent = u_ff;
                  if (v_rd_ff.mate == '0) begin
                     w_in     = v_ff;
                     v_raddr  = v_ff;
                     state_in = ST_FLIP_W;
                  end else begin
                     w_in     = v_rd_ff.mate;
                     v_raddr  = v_rd_ff.mate;
                     state_in = ST_M_WR;
                  end
               end
               default: begin
                  state_in = ST_CB_START;
               end
            endcase
         end
         ST_M_WR: begin
            v_we         = 1'b1;
            v_waddr      = w_ff;
            v_wrec.label = LBL_OUTER;
            push_req     = 1'b1;
            push_vtx     = w_ff;
            state_in     = ST_E_CHK;
         end
         ST_FLIP_W: begin
            v_we        = 1'b1;
            v_waddr     = w_ff;
            v_wrec.mate = v_rd_ff.parent;
            v_raddr     = v_rd_ff.parent;
            state_in    = ST_FLIP_PW;
         end
         ST_FLIP_PW: begin
            v_we        = 1'b1;
            v_waddr     = pw_hold_ff;
            v_wrec.mate = w_ff;
            w_in        = v_rd_ff.mate;
            if (v_rd_ff.mate == '0) begin
               v_raddr  = s_ff;
               state_in = ST_FLIP_DONE;
            end else begin
               v_raddr  = v_rd_ff.mate;
               state_in = ST_FLIP_W;
            end
         end
         ST_FLIP_DONE: begin
            found_in = 1'b1;
            mate_in  = v_rd_ff.mate;
            state_in = ST_FINISH;
         end
         ST_CB_START: begin
            if (st_next == '0) begin
               st_in    = SW'(1);
               ix_in    = '0;
               v_raddr  = '0;
               state_in = ST_STAMP_WR;
            end else begin
               st_in    = st_next;
               call_req = 1'b1;
               call_x   = u_ff;
               call_ret = ST_CB_RB;
            end
         end
         ST_STAMP_WR: begin
            v_we         = 1'b1;
            v_waddr      = ix_ff;
            v_wrec.stamp = '0;
            if (ix_ff == VW'(NV - 1)) begin
               call_req = 1'b1;
               call_x   = u_ff;
               call_ret = ST_CB_RB;
            end else begin
               ix_in   = ix_ff + VW'(1);
               v_raddr = ix_ff + VW'(1);
            end
         end
         ST_CB_RB: begin
            a_in     = rx_ff;
            call_req = 1'b1;
            call_x   = v_ff;
            call_ret = ST_CB_LOOP;
         end
         ST_CB_LOOP: begin
            b_in     = rx_ff;
            v_raddr  = a_ff;
            state_in = ST_CB_CHK;
         end
         ST_CB_CHK: begin
            if (v_rd_ff.stamp == st_ff) begin
               base_in  = a_ff;
               ca_in    = u_ff;
               cb_in    = v_ff;
               ct2_in   = 1'b0;
               state_in = ST_CT_BEGIN;
            end else begin
               v_we         = 1'b1;
               v_waddr      = a_ff;
               v_wrec.stamp = st_ff;
               v_raddr      = v_rd_ff.mate;
               state_in     = ST_CB_M;
            end
         end
         ST_CB_M: begin
            call_req = 1'b1;
            call_x   = v_rd_ff.parent;
            call_ret = ST_CB_NEXT;
         end
         // alternate the two walks while the second one is still alive
         ST_CB_NEXT: begin
            if (b_ff != '0) begin
               a_in    = b_ff;
               b_in    = rx_ff;
               v_raddr = b_ff;
            end else begin
               a_in    = rx_ff;
               v_raddr = rx_ff;
            end
            state_in = ST_CB_CHK;
         end
         ST_CT_BEGIN: begin
            call_req = 1'b1;
            call_x   = ca_ff;
            call_ret = ST_CT_R;
         end
         ST_CT_R: begin
            if (rx_ff == base_ff) begin
               if (!ct2_ff) begin
                  ca_in    = v_ff;
                  cb_in    = u_ff;
                  ct2_in   = 1'b1;
                  state_in = ST_CT_BEGIN;
               end else begin
                  state_in = ST_E_CHK;
               end
            end else begin
               self_in  = (rx_ff == ca_ff);
               v_raddr  = ca_ff;
               state_in = ST_CT_A;
            end
         end
         ST_CT_A: begin
            v_we          = 1'b1;
            v_waddr       = ca_ff;
            v_wrec.parent = cb_ff;
            if (self_ff) begin
               v_wrec.base = base_ff;
            end
            cb_in    = v_rd_ff.mate;
            v_raddr  = v_rd_ff.mate;
            state_in = ST_CT_B;
         end
         ST_CT_B: begin
            pb_in = v_rd_ff.parent;
            if (v_rd_ff.label == LBL_INNER) begin
               v_we         = 1'b1;
               v_waddr      = cb_ff;
               v_wrec.label = LBL_OUTER;
               push_req     = 1'b1;
               push_vtx     = cb_ff;
            end
            call_req = 1'b1;
            call_x   = cb_ff;
            call_ret = ST_CT_RB;
         end
         ST_CT_RB: begin
            if (rx_ff == cb_ff) begin
               v_we        = 1'b1;
               v_waddr     = cb_ff;
               v_wrec.base = base_ff;
            end
            ca_in    = pb_ff;
            state_in = ST_CT_BEGIN;
         end
         ST_FINISH: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push_req && (32'(qwr_ff) < 32'(MAX_VERTICES))) begin
         e_we           = 1'b1;
         e_waddr        = EAW'(ECAP) + EAW'(qwr_ff);
         e_wdata.target = push_vtx;
         e_wdata.link   = '0;
         qwr_in         = qwr_ff + QW'(1);
      end

      if (call_req) begin
         rx_in    = call_x;
         v_raddr  = call_x;
         ret_in   = call_ret;
         state_in = ST_ROOT;
      end
   end

   // partner address during the flip is the parent read in the previous step
   always_ff @(posedge clock) begin
      if (state_ff == ST_FLIP_W) begin
         pw_hold_ff <= v_rd_ff.parent;
      end
   end

   always_ff @(posedge clock) begin
      if (v_we) begin
         vmem[v_waddr] <= v_wrec;
      end
      if (v_we && (v_waddr == v_raddr)) begin
         v_rd_ff <= v_wrec;
      end else begin
         v_rd_ff <= vmem[v_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (e_we) begin
         emem[e_waddr] <= e_wdata;
      end
      e_rd_ff <= emem[e_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOT;
         ret_ff   <= ST_IDLE;
         ix_ff    <= '0;
         fill_ff  <= '0;
         st_ff    <= '0;
         qrd_ff   <= '0;
         qwr_ff   <= '0;
         ct2_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         ix_ff    <= ix_in;
         fill_ff  <= fill_in;
         st_ff    <= st_in;
         qrd_ff   <= qrd_in;
         qwr_ff   <= qwr_in;
         ct2_ff   <= ct2_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff      <= s_in;
      u_ff      <= u_in;
      v_ff      <= v_in;
      w_ff      <= w_in;
      rx_ff     <= rx_in;
      ru_ff     <= ru_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      base_ff   <= base_in;
      ca_ff     <= ca_in;
      cb_ff     <= cb_in;
      pb_ff     <= pb_in;
      e_ff      <= e_in;
      self_ff   <= self_in;
      found_ff  <= found_in;
      mate_ff   <= mate_in;
      status_ff <= status_in;
   end

   assign ready      = (state_ff == ST_IDLE);
   assign rsp.found  = found_ff;
   assign rsp.mate   = PORT_VW'(mate_ff);
   assign rsp.status = status_ff;

   `GGBM_ASSERT_NOW(a_start_idle, clock, reset, start, state_ff == ST_IDLE)
   `GGBM_ASSERT_NOW(a_queue_order, clock, reset, 1'b1, qrd_ff <= qwr_ff)
   `GGBM_ASSERT_NOW(a_fill_cap, clock, reset, 1'b1, 32'(fill_ff) <= 32'(ECAP))
   `GGBM_ASSERT_NEXT(a_done_pulse, clock, reset, done, (state_ff == ST_IDLE) && !done)

endmodule

// ===== tb/sv/ggbm_checker.sv =====
module ggbm_checker import ggbm_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [ACTION_WIDTH-1:0] req_action,
   input  logic [PORT_VW-1:0]      req_first_vertex,
   input  logic [PORT_VW-1:0]      req_second_vertex,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic                    rsp_found,
   input  logic [PORT_VW-1:0]      rsp_mate,
   input  logic                    rsp_status,
   output int                      fail_count,
   output int                      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NV   = DEF_MAX_VERTICES;
   localparam int ECAP = 2 * DEF_MAX_EDGES;

   logic [9:0]               head_of   [0:NV];
   logic [6:0]               edge_dst  [0:ECAP-1];
   logic [9:0]               edge_nxt  [0:ECAP-1];
   int                       edge_used;
   logic [6:0]               partner   [0:NV];
   logic [1:0]               vlabel    [0:NV];
   logic [6:0]               back_link [0:NV];
   logic [6:0]               base_of   [0:NV];
   logic [DEF_STAMP_WIDTH-1:0] seen    [0:NV];
   logic [DEF_STAMP_WIDTH-1:0] stamp_now;
   logic [6:0]               bfs_fifo  [0:NV-1];
   int                       bfs_rd, bfs_wr;

   rsp_type expected_q[$];
   int      errors = 0;

   function automatic void bfs_push(logic [6:0] v);
      if (bfs_wr < NV) begin
         bfs_fifo[bfs_wr] = v;
         bfs_wr++;
      end
   endfunction

   // union-find lookup with path halving
   function automatic logic [6:0] find_base(logic [6:0] x);
      while (x != base_of[x]) begin
         base_of[x] = base_of[base_of[x]];
         x = base_of[x];
      end
      return x;
   endfunction

   function automatic logic [DEF_STAMP_WIDTH-1:0] bump_stamp();
      stamp_now = stamp_now + 1'b1;
      if (stamp_now == '0) begin
         for (int i = 0; i <= NV; i++) seen[i] = '0;
         stamp_now = DEF_STAMP_WIDTH'(1);
      end
      return stamp_now;
   endfunction

   function automatic logic [6:0] lowest_common_base(logic [6:0] a, logic [6:0] b);
      logic [DEF_STAMP_WIDTH-1:0] st;
      logic [6:0] t;
      st = bump_stamp();
      a = find_base(a);
      b = find_base(b);
      while (seen[a] != st) begin
         seen[a] = st;
         a = find_base(back_link[partner[a]]);
         if (b != 0) begin
            t = a;
            a = b;
            b = t;
         end
      end
      return a;
   endfunction

   function automatic void shrink_blossom(logic [6:0] a, logic [6:0] b, logic [6:0] bs);
      while (find_base(a) != bs) begin
         back_link[a] = b;
         b = partner[a];
         if (vlabel[b] == LBL_INNER) begin
            vlabel[b] = LBL_OUTER;
            bfs_push(b);
         end
         if (find_base(a) == a) base_of[a] = bs;
         if (find_base(b) == b) base_of[b] = bs;
         a = back_link[b];
      end
   endfunction

   function automatic logic search_path(logic [6:0] s);
      logic [6:0] u, v, w, pw, nx, bs;
      logic [9:0] e;
      for (int i = 0; i <= NV; i++) begin
         vlabel[i]    = LBL_NONE;
         back_link[i] = '0;
         base_of[i]   = 7'(i);
      end
      bfs_rd = 0;
      bfs_wr = 0;
      bfs_push(s);
      vlabel[s] = LBL_OUTER;
      while (bfs_rd < bfs_wr) begin
         u = bfs_fifo[bfs_rd];
         bfs_rd++;
         for (e = head_of[u]; e != 0; e = edge_nxt[e-1]) begin
            v = edge_dst[e-1];
            if (find_base(u) == find_base(v) || vlabel[v] == LBL_INNER) continue;
            if (vlabel[v] == LBL_NONE) begin
               vlabel[v] = LBL_INNER;
               back_link[v] = u;
               if (partner[v] == 0) begin
                  // flip the alternating path back to the root
                  for (w = v; w != 0; w = nx) begin
                     pw = back_link[w];
                     nx = partner[pw];
                     partner[w] = pw;
                     partner[pw] = w;
                  end
                  return 1'b1;
               end
               vlabel[partner[v]] = LBL_OUTER;
               bfs_push(partner[v]);
            end else begin
               bs = lowest_common_base(u, v);
               shrink_blossom(u, v, bs);
               shrink_blossom(v, u, bs);
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic rsp_type predict_matching(logic [1:0] act, logic [6:0] a, logic [6:0] b);
      rsp_type r;
      logic a_ok, b_ok;
      r = '0;
      a_ok = (a >= 1 && a <= NV);
      b_ok = (b >= 1 && b <= NV);
      case (act)
         ACT_ADD_EDGE: begin
            if (a_ok && b_ok) begin
               if (edge_used + 2 > ECAP) begin
                  r.status = 1'b1;
               end else begin
                  edge_dst[edge_used] = b;
                  edge_nxt[edge_used] = head_of[a];
                  head_of[a] = 10'(edge_used + 1);
                  edge_used++;
                  edge_dst[edge_used] = a;
                  edge_nxt[edge_used] = head_of[b];
                  head_of[b] = 10'(edge_used + 1);
                  edge_used++;
               end
            end
         end
         ACT_AUGMENT: begin
            if (a_ok) begin
               if (partner[a] == 0) r.found = search_path(a);
               r.mate = partner[a];
            end
         end
         ACT_READ_MATE: begin
            if (a_ok) r.mate = partner[a];
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i <= NV; i++) begin
            head_of[i] = '0;
            partner[i] = '0;
            seen[i]    = '0;
            base_of[i] = 7'(i);
         end
         edge_used = 0;
         stamp_now = '0;
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_found !== want.found) report_mismatch("found", rsp_found, want.found);
               if (rsp_mate !== want.mate) report_mismatch("mate", rsp_mate, want.mate);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready)
            expected_q.push_back(predict_matching(req_action, req_first_vertex,
                                                  req_second_vertex));
      end
      fail_count    <= errors;
      pending_count <= expected_q.size();
   end
endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top import ggbm_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1150;
   localparam int STALL_LIMIT  = 1000000;
   localparam logic [ACTION_WIDTH-1:0] ACT_SPARE = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [ACTION_WIDTH-1:0] req_action = ACT_ADD_EDGE;
   logic [PORT_VW-1:0]      req_first_vertex = '0;
   logic [PORT_VW-1:0]      req_second_vertex = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_found;
   logic [PORT_VW-1:0]      rsp_mate;
   logic                    rsp_status;
   int                      fail_count, pending_count;
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;
   int                      quiet_cycles = 0;

   always #4 clock = ~clock;

   general_graph_blossom_matching_top dut (.*);

   ggbm_checker checker_i (.*);

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] act, logic [6:0] a, logic [6:0] b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= act;
      req_first_vertex  <= a;
      req_second_vertex <= b;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic logic [6:0] pick_vertex();
      if ($urandom_range(99) < 4) return 7'($urandom);
      return 7'($urandom_range(1, 64));
   endfunction

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int pick;
      logic [1:0] act;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: bad endpoints, self loop, odd cycle, matched start, spare action
      send_beat(ACT_ADD_EDGE, 7'd1, 7'd2);
      send_beat(ACT_ADD_EDGE, 7'd0, 7'd5);
      send_beat(ACT_ADD_EDGE, 7'd65, 7'd3);
      send_beat(ACT_ADD_EDGE, 7'd3, 7'd127);
      send_beat(ACT_ADD_EDGE, 7'd64, 7'd64);
      send_beat(ACT_READ_MATE, 7'd1, 7'd0);
      send_beat(ACT_AUGMENT, 7'd64, 7'd0);
      send_beat(ACT_AUGMENT, 7'd1, 7'd0);
      send_beat(ACT_AUGMENT, 7'd1, 7'd0);
      send_beat(ACT_AUGMENT, 7'd0, 7'd0);
      send_beat(ACT_AUGMENT, 7'd100, 7'd0);
      send_beat(ACT_READ_MATE, 7'd0, 7'd0);
      send_beat(ACT_READ_MATE, 7'd127, 7'd0);
      send_beat(ACT_SPARE, 7'd127, 7'd127);
      send_beat(ACT_SPARE, 7'd0, 7'd0);
      send_beat(ACT_ADD_EDGE, 7'd2, 7'd3);
      send_beat(ACT_ADD_EDGE, 7'd3, 7'd1);
      send_beat(ACT_ADD_EDGE, 7'd3, 7'd4);
      send_beat(ACT_ADD_EDGE, 7'd4, 7'd5);
      send_beat(ACT_ADD_EDGE, 7'd5, 7'd6);
      send_beat(ACT_AUGMENT, 7'd6, 7'd0);
      send_beat(ACT_AUGMENT, 7'd4, 7'd0);
      send_beat(ACT_READ_MATE, 7'd3, 7'd0);
      send_beat(ACT_READ_MATE, 7'd64, 7'd0);
      drain_results();

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 290 == 0) begin
            case (i / 290)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
               default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            drain_results();
         end
         pick = $urandom_range(99);
         // edges run out near the end, so later adds hit the full store
         if (pick < 35) act = ACT_ADD_EDGE;
         else if (pick < 75) act = ACT_AUGMENT;
         else if (pick < 97) act = ACT_READ_MATE;
         else act = ACT_SPARE;
         send_beat(act, pick_vertex(), pick_vertex());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/ggbm_pkg.sv
src/ggbm_core.sv
src/general_graph_blossom_matching_top.sv
tb/sv/ggbm_checker.sv
tb/sv/tb_top.sv
